>>> sv/rtdms_pkg.sv
package rtdms_pkg;

  localparam int ADC_BITS_DEF = 24;
  localparam int SAMPLE_W     = 24;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 48;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int SPP_MAX      = 8;

  localparam logic [7:0] SETTLE_MS_RST   = 8'd10;
  localparam logic [3:0] SPP_RST         = 4'd5;
  localparam logic [7:0] REF_REG_RST     = 8'h25;
  localparam logic [7:0] SENSE_A_REG_RST = 8'h45;
  localparam logic [7:0] SENSE_B_REG_RST = 8'h55;
  localparam logic [2:0] REF_WAY_RST     = 3'd7;
  localparam logic [2:0] SENSE_WAY_RST   = 3'd0;

  localparam logic [1:0] PH_REF     = 2'd0;
  localparam logic [1:0] PH_SENSE_A = 2'd1;
  localparam logic [1:0] PH_SENSE_B = 2'd2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SETTLE_MS   = 3'd0,
    CFG_SPP         = 3'd1,
    CFG_REF_REG     = 3'd2,
    CFG_SENSE_A_REG = 3'd3,
    CFG_SENSE_B_REG = 3'd4,
    CFG_REF_WAY     = 3'd5,
    CFG_SENSE_WAY   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_SELECT  = 2'd1,
    ST_SETTLE  = 2'd2,
    ST_CONVERT = 2'd3
  } seq_state_t;

  typedef struct packed {
    logic [7:0] settle_ms;
    logic [3:0] samples_per_phase;
    logic [7:0] ref_phase_reg;
    logic [7:0] sense_a_reg;
    logic [7:0] sense_b_reg;
    logic [2:0] ref_phase_way;
    logic [2:0] sense_phase_way;
  } cfg_t;

  typedef struct packed {
    logic                seq_done;
    logic [2:0]          sample_index;
    logic [1:0]          sample_phase;
    logic [SAMPLE_W-1:0] sample_value;
    logic                sample_valid;
    logic                start_conv;
    logic [7:0]          reg_value;
    logic                reg_write;
    logic [2:0]          mux_way;
    logic                mux_strobe;
    logic                phase_last;
  } res_t;

endpackage

>>> sv/rtdms_cfg.sv
module rtdms_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rtdms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rtdms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rtdms_pkg::cfg_t                  cfg
);
  import rtdms_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ms         <= SETTLE_MS_RST;
      cfg_r.samples_per_phase <= SPP_RST;
      cfg_r.ref_phase_reg     <= REF_REG_RST;
      cfg_r.sense_a_reg       <= SENSE_A_REG_RST;
      cfg_r.sense_b_reg       <= SENSE_B_REG_RST;
      cfg_r.ref_phase_way     <= REF_WAY_RST;
      cfg_r.sense_phase_way   <= SENSE_WAY_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_SETTLE_MS:   cfg_r.settle_ms         <= cfg_wdata;
        CFG_SPP:         cfg_r.samples_per_phase <= cfg_wdata[3:0];
        CFG_REF_REG:     cfg_r.ref_phase_reg     <= cfg_wdata;
        CFG_SENSE_A_REG: cfg_r.sense_a_reg       <= cfg_wdata;
        CFG_SENSE_B_REG: cfg_r.sense_b_reg       <= cfg_wdata;
        CFG_REF_WAY:     cfg_r.ref_phase_way     <= cfg_wdata[2:0];
        CFG_SENSE_WAY:   cfg_r.sense_phase_way   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/rtdms_fsm.sv
module rtdms_fsm #(
  parameter int ADC_BITS = rtdms_pkg::ADC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rtdms_pkg::cfg_t                cfg,
  input  logic                           adv,
  input  logic                           start_req,
  input  logic                           tick_ms,
  input  logic                           drdy_n,
  input  logic [rtdms_pkg::SAMPLE_W-1:0] adc_code,
  output rtdms_pkg::res_t                res
);
  import rtdms_pkg::*;

  seq_state_t state_r, state_nxt, st;
  logic [1:0] phase_r, phase_nxt, ph;
  logic [2:0] smp_cnt_r, smp_cnt_nxt;
  logic [7:0] settle_r, settle_nxt, settle_dec;
  logic [3:0] spp;
  logic       last_smp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      phase_r   <= PH_REF;
      smp_cnt_r <= '0;
      settle_r  <= '0;
    end else if (adv) begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      smp_cnt_r <= smp_cnt_nxt;
      settle_r  <= settle_nxt;
    end
  end

  always_comb begin
    st  = start_req ? ST_SELECT : state_r;
    ph  = start_req ? PH_REF : phase_r;
    spp = (cfg.samples_per_phase == 4'd0) ? 4'd1 :
          (cfg.samples_per_phase > 4'(SPP_MAX)) ? 4'(SPP_MAX) : cfg.samples_per_phase;
    last_smp   = ({1'b0, smp_cnt_r} + 4'd1) >= spp;
    settle_dec = (tick_ms && settle_r != 8'd0) ? settle_r - 8'd1 : settle_r;

    state_nxt   = st;
    phase_nxt   = ph;
    smp_cnt_nxt = smp_cnt_r;
    settle_nxt  = settle_r;
    res         = '0;

    case (st)
      ST_SELECT: begin
        case (ph)
          PH_REF: begin
            res.mux_strobe = 1'b1;
            res.mux_way    = cfg.ref_phase_way;
            res.reg_value  = cfg.ref_phase_reg;
          end
          PH_SENSE_A: begin
            res.mux_strobe = 1'b1;
            res.mux_way    = cfg.sense_phase_way;
            res.reg_value  = cfg.sense_a_reg;
          end
          default: res.reg_value = cfg.sense_b_reg;
        endcase
        res.reg_write = 1'b1;
        settle_nxt    = cfg.settle_ms;
        smp_cnt_nxt   = '0;
        state_nxt     = ST_SETTLE;
      end
      ST_SETTLE: begin
        settle_nxt = settle_dec;
        if (settle_dec == 8'd0) begin
          res.start_conv = 1'b1;
          state_nxt      = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (!drdy_n) begin
          res.sample_valid = 1'b1;
          res.sample_value = SAMPLE_W'(adc_code[ADC_BITS-1:0]);
          res.sample_phase = ph;
          res.sample_index = smp_cnt_r;
          if (last_smp) begin
            res.phase_last = 1'b1;
            smp_cnt_nxt    = '0;
            if (ph >= PH_SENSE_B) begin
              res.seq_done = 1'b1;
              phase_nxt    = PH_REF;
              state_nxt    = ST_IDLE;
            end else begin
              phase_nxt = ph + 2'd1;
              state_nxt = ST_SELECT;
            end
          end else begin
            smp_cnt_nxt    = smp_cnt_r + 3'd1;
            res.start_conv = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> sv/rtd_adc_measurement_sequencer_unit.sv
// RTD measurement sequencer for a delta-sigma ADC behind an analog mux.
// Input stream: one item per poll of the converter (start request, millisecond
// tick, data-ready level, 24-bit code). Every accepted item yields exactly one
// result item carrying mux strobe/way, ADC register 0 write, start-conversion
// and, when a sample was taken, its value, phase and index; out_tlast marks
// the last sample of a phase, seq_done the end of the sense B phase.
// A start request restarts at the reference phase from any state.
// An accepted item passes the input register and then the result register.
// Throughput is one item per clock while the receiver does not stall; the
// sequencer state updates once per item as it moves from the input register
// into the result register. When the receiver stalls, the result register
// holds, the input register fills and in_tready drops until out_tready
// returns; nothing is lost. Configuration registers must be written through
// cfg_we/cfg_addr/cfg_wdata by the user only while no item is in flight; the
// block does not enforce this. rst_n (synchronous) empties both registers,
// returns the sequencer to idle and loads the default configuration.
module rtd_adc_measurement_sequencer_unit #(
  parameter int ADC_BITS = rtdms_pkg::ADC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_req[0], tick_ms[1], drdy_n[2], adc_code[26:3], zero fill
  input  logic [rtdms_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // mux_strobe[0], mux_way[3:1], reg_write[4], reg_value[12:5], start_conv[13],
  // sample_valid[14], sample_value[38:15], sample_phase[40:39],
  // sample_index[43:41], seq_done[44], zero fill
  output logic [rtdms_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [rtdms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [rtdms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rtdms_pkg::*;

  cfg_t                cfg;
  res_t                res;
  res_t                res_r;
  logic                in_vld_r, out_vld_r, adv;
  logic                start_r, tick_r, drdy_n_r;
  logic [SAMPLE_W-1:0] code_r;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      if (adv) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      start_r  <= in_tdata[0];
      tick_r   <= in_tdata[1];
      drdy_n_r <= in_tdata[2];
      code_r   <= in_tdata[3 +: SAMPLE_W];
    end
    if (adv) res_r <= res;
  end

  rtdms_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rtdms_fsm #(
    .ADC_BITS (ADC_BITS)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .adv       (adv),
    .start_req (start_r),
    .tick_ms   (tick_r),
    .drdy_n    (drdy_n_r),
    .adc_code  (code_r),
    .res       (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tlast  = res_r.phase_last;
  assign out_tdata  = {3'b000, res_r.seq_done, res_r.sample_index, res_r.sample_phase,
                       res_r.sample_value, res_r.sample_valid, res_r.start_conv,
                       res_r.reg_value, res_r.reg_write, res_r.mux_way,
                       res_r.mux_strobe};

endmodule

>>> sv/rtdms_checker.sv
module rtdms_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rtdms_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tlast
);
  import rtdms_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[44] |-> out_tlast && out_tdata[14])
    else $error("seq_done without last sample");

  a_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[14] |-> !out_tlast && out_tdata[44:15] == '0)
    else $error("sample fields set without sample");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> !out_tdata[14] && !out_tdata[13])
    else $error("register write mixed with conversion");

  a_way: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[3:1] == 3'd0)
    else $error("mux way without strobe");

endmodule

bind rtd_adc_measurement_sequencer_unit rtdms_checker u_rtdms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
